// File: rtl/core/jds_pkg.sv
package jds_pkg;

  // Field widths of one item and of the configuration registers.
  localparam int unsigned PadW    = 8;
  localparam int unsigned YawW    = 13;
  localparam int unsigned AxisW   = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 2;

  // Shared multiplier operand and result widths.
  localparam int unsigned MulAW   = 19;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned MulPW   = MulAW + MulBW;
  localparam int unsigned MulRW   = 24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDeadzone     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDeadzoneGain = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSpeedFactor  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSmoothFactor = 2'd3;

  // Round-to-nearest right shift applied after the multiply.
  typedef enum logic [1:0] {
    SH_12,
    SH_14,
    SH_16
  } shift_e;

  typedef struct packed {
    logic [PadW-1:0] pad_x;
    logic [PadW-1:0] pad_y;
    logic [YawW-1:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [AxisW-1:0] smooth_x;
    logic signed [AxisW-1:0] smooth_y;
    logic [YawW-1:0]         yaw_out;
    logic [CountW-1:0]       sample_count;
    logic                    is_active;
  } out_item_t;

endpackage

// File: rtl/core/joystick_deadzone_smoother_unit.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (pad_x, pad_y, yaw_angle)
// out       output     out_valid_o / out_ready_i  out_data_o (smooth_x, smooth_y, yaw_out,
//                                                  sample_count, is_active)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Items are taken only in the idle step: one shared multiplier is used three times per
// axis (deadzone gain, speed factor, smoothing weight), four sequencer steps per axis,
// one step that writes the result and one idle step that takes the next item.
// Reset clears the held axes and the sample counter and returns the configuration
// registers to their default values. A result waits in the output register; the next
// item is accepted and worked on meanwhile, and only the final write step stalls while
// the output is still full.
module joystick_deadzone_smoother_unit import jds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHAPE,
    S_SPEED,
    S_SAT,
    S_SMOOTH,
    S_DONE
  } state_e;

  state_e state_q;
  logic   axis_q;

  // Configuration registers.
  logic [15:0]     dz_q;
  logic [15:0]     gain_q;
  logic [15:0]     speed_q;
  logic [CfgW-1:0] sf_q;

  // Held state.
  logic signed [AxisW-1:0] held_x_q;
  logic signed [AxisW-1:0] held_y_q;
  logic [CountW-1:0]       count_q;
  logic                    active_q;

  // Per-item working registers.
  in_item_t  in_q;
  logic      neg_q;
  logic      zero_q;
  logic      diff_neg_q;
  logic      out_valid_q;
  out_item_t out_q;

  // Datapath signals.
  logic [PadW-1:0]         pad_sel;
  logic [PadW-1:0]         ax_mag;
  logic                    ax_neg;
  logic [14:0]             m_val;
  logic [16:0]             m16;
  logic                    below;
  logic [16:0]             dz_diff;
  logic [14:0]             tmag;
  logic signed [AxisW-1:0] target;
  logic signed [AxisW-1:0] held_sel;
  logic signed [AxisW:0]   diff;
  logic [AxisW-1:0]        diff_mag;
  logic [CfgW-1:0]         s_eff;
  logic signed [AxisW:0]   held_new;
  logic [MulAW-1:0]        mul_a;
  logic [MulBW-1:0]        mul_b;
  shift_e                  mul_sh;
  logic [MulRW-1:0]        mul_res;

  // Axis shaping: |raw - 127| scaled to Q2.14. Since 16384 = 127 * 129 + 1, the
  // rounded quotient is mag * 129 plus one whenever mag reaches 64.
  always_comb begin
    pad_sel = axis_q ? in_q.pad_y : in_q.pad_x;
    ax_mag  = (pad_sel >= 8'd127) ? pad_sel - 8'd127 : 8'd127 - pad_sel;
    // The forward axis is inverted, so its sign flips.
    ax_neg  = axis_q ? (pad_sel > 8'd127) : (pad_sel < 8'd127);
    m_val   = 15'(ax_mag) * 15'd129 + {14'b0, ax_mag[7] | ax_mag[6]};
    m16     = {m_val, 2'b00};
    below   = m16 < {1'b0, dz_q};
    dz_diff = m16 - {1'b0, dz_q};
  end

  // Saturation, sign, the difference to the held value and the smoothed update.
  always_comb begin
    tmag     = (mul_res > MulRW'(16384)) ? 15'd16384 : mul_res[14:0];
    if (zero_q) begin
      target = '0;
    end else if (neg_q) begin
      target = -$signed({1'b0, tmag});
    end else begin
      target = $signed({1'b0, tmag});
    end
    held_sel = axis_q ? held_y_q : held_x_q;
    diff     = {target[AxisW-1], target} - {held_sel[AxisW-1], held_sel};
    diff_mag = diff[AxisW] ? AxisW'(-diff) : diff[AxisW-1:0];
    s_eff    = (sf_q > 17'd65536) ? 17'd65536 : sf_q;
    held_new = diff_neg_q ? {held_sel[AxisW-1], held_sel} - $signed({1'b0, mul_res[15:0]})
                          : {held_sel[AxisW-1], held_sel} + $signed({1'b0, mul_res[15:0]});
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_q)
      S_SPEED: begin
        mul_a  = mul_res[MulAW-1:0];
        mul_b  = {1'b0, speed_q};
        mul_sh = SH_12;
      end
      S_SAT: begin
        mul_a  = {3'b0, diff_mag};
        mul_b  = s_eff;
        mul_sh = SH_16;
      end
      default: begin
        mul_a  = {2'b0, dz_diff};
        mul_b  = {1'b0, gain_q};
        mul_sh = SH_14;
      end
    endcase
  end

  jds_mul_unit u_mul (
    .clk_i   (clk_i),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .shift_i (mul_sh),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      dz_q        <= 16'd0;
      gain_q      <= 16'd4096;
      speed_q     <= 16'd4096;
      sf_q        <= 17'd65536;
      held_x_q    <= '0;
      held_y_q    <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegDeadzone:     dz_q    <= cfg_data_i[15:0];
          RegDeadzoneGain: gain_q  <= cfg_data_i[15:0];
          RegSpeedFactor:  speed_q <= cfg_data_i[15:0];
          RegSmoothFactor: sf_q    <= cfg_data_i;
        endcase
      end

      // In the write step the valid flag is handled there, since a new result
      // may replace the one that leaves.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            axis_q  <= 1'b0;
            state_q <= S_SHAPE;
          end
        end
        S_SHAPE: begin
          neg_q   <= ax_neg;
          zero_q  <= below;
          state_q <= S_SPEED;
        end
        S_SPEED: begin
          state_q <= S_SAT;
        end
        S_SAT: begin
          diff_neg_q <= diff[AxisW];
          state_q    <= S_SMOOTH;
        end
        S_SMOOTH: begin
          if (axis_q) begin
            held_y_q <= held_new[AxisW-1:0];
            state_q  <= S_DONE;
          end else begin
            held_x_q <= held_new[AxisW-1:0];
            axis_q   <= 1'b1;
            state_q  <= S_SHAPE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.smooth_x     <= held_x_q;
            out_q.smooth_y     <= held_y_q;
            out_q.yaw_out      <= in_q.yaw_angle;
            out_q.sample_count <= count_q + 32'd1;
            out_q.is_active    <= 1'b1;
            count_q            <= count_q + 32'd1;
            active_q           <= 1'b1;
            out_valid_q        <= 1'b1;
            axis_q             <= 1'b0;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted item always starts with the first axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_SHAPE && !axis_q)
    else $error("item accepted without starting the lateral axis");

  // A freshly loaded result carries the updated sample counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_q.sample_count == count_q && active_q)
    else $error("result sample count out of step with counter");

  // The held axes never leave the range of plus or minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_x_q <= 16'sd16384 && held_x_q >= -16'sd16384 &&
    held_y_q <= 16'sd16384 && held_y_q >= -16'sd16384)
    else $error("held axis out of range");

  // The axis select is back on the lateral axis whenever the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !axis_q)
    else $error("axis select left set while idle");

endmodule

// File: rtl/core/jds_mul_unit.sv
module jds_mul_unit import jds_pkg::*; (
  input  logic             clk_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  input  shift_e           shift_i,
  output logic [MulRW-1:0] res_o
);

  logic [MulPW-1:0] prod;
  logic [MulPW:0]   rnd;
  logic [MulRW-1:0] res_d;
  logic [MulRW-1:0] res_q;

  // Unsigned multiply followed by a rounding shift, halves rounded up.
  always_comb begin
    prod = a_i * b_i;
    unique case (shift_i)
      SH_12: begin
        rnd   = {1'b0, prod} + (MulPW+1)'(1 << 11);
        res_d = MulRW'(rnd >> 12);
      end
      SH_14: begin
        rnd   = {1'b0, prod} + (MulPW+1)'(1 << 13);
        res_d = MulRW'(rnd >> 14);
      end
      SH_16: begin
        rnd   = {1'b0, prod} + (MulPW+1)'(1 << 15);
        res_d = MulRW'(rnd >> 16);
      end
      default: begin
        rnd   = {1'b0, prod};
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// File: tb/tb_joystick_deadzone_smoother_unit.sv
`timescale 1ns / 100ps

module tb_joystick_deadzone_smoother_unit;
  import jds_pkg::*;

  // Before any register write we wait this long once the last result is back, so that
  // the sequencer is at rest.
  localparam int unsigned DRAIN_GAP   = 12;
  // Length of the one long stretch in which the result side refuses every item.
  localparam int unsigned HOLD_CYCLES = 150;
  // Cycles without any handshake after which the run is declared hung.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam int unsigned DIR_ROWS    = 33;

  // A row of the directed table is either one item to send or one register write.
  typedef enum logic {
    ROW_SAMPLE,
    ROW_REG
  } row_kind_e;

  // On sample rows the register columns are unused, and on register rows the item
  // columns are unused. The typed axes hold only when fixed is set.
  typedef struct packed {
    row_kind_e               kind;
    logic [CfgIdxW-1:0]      reg_idx;
    logic [CfgW-1:0]         reg_val;
    logic [PadW-1:0]         pad_x;
    logic [PadW-1:0]         pad_y;
    logic [YawW-1:0]         yaw;
    logic                    fixed;
    logic signed [AxisW-1:0] want_x;
    logic signed [AxisW-1:0] want_y;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  // Our own copy of the configuration and of the block's running state.
  logic [15:0]             dz_thresh;
  logic [15:0]             dz_rescale;
  logic [15:0]             speed_mul;
  logic [16:0]             blend_weight;
  logic signed [AxisW-1:0] lat_held;
  logic signed [AxisW-1:0] fwd_held;
  logic [CountW-1:0]       samples_seen;

  // Results still owed by the block, oldest first.
  out_item_t   pending_results[$];
  int unsigned fails;
  int unsigned results_checked;
  int unsigned samples_sent;
  int unsigned settings_used;
  bit          gaps_on;
  bit          hold_req;

  // The directed part. Reset defaults first (center, full deflection each way,
  // yaw at its top and beyond it), then every register at its maximum with the
  // smoothing weight above one, then a zero and a small gain (below one), a frozen
  // smoothing weight, a half weight with double speed, and a half-width deadzone.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd127, 8'd127, 13'd0,    1'b1, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd255, 8'd0,   13'd5759, 1'b1,
      16384, 16384},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd0,   8'd255, 13'd8191, 1'b1,
      -16384, -16384},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd128, 8'd126, 13'd5760, 1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd126, 8'd128, 13'd4095, 1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd170, 8'd85,  13'd2880, 1'b0, 0, 0},
    '{ROW_REG,    RegDeadzone,     17'd65535,  8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegDeadzoneGain, 17'd65535,  8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSpeedFactor,  17'd65535,  8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSmoothFactor, 17'd131071, 8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd255, 8'd0,   13'd1,    1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd0,   8'd255, 13'd4096, 1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd200, 8'd50,  13'd100,  1'b1, 0, 0},
    '{ROW_REG,    RegDeadzone,     17'd0,      8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegDeadzoneGain, 17'd0,      8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSmoothFactor, 17'd65536,  8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSpeedFactor,  17'd4096,   8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd255, 8'd0,   13'd0,    1'b1, 0, 0},
    '{ROW_REG,    RegDeadzoneGain, 17'd1000,   8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd0,   8'd255, 13'd7000, 1'b0, 0, 0},
    '{ROW_REG,    RegDeadzoneGain, 17'd4096,   8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSmoothFactor, 17'd0,      8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd255, 8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSmoothFactor, 17'd32768,  8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSpeedFactor,  17'd8192,   8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd191, 8'd63,  13'd1234, 1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd191, 8'd63,  13'd1234, 1'b0, 0, 0},
    '{ROW_REG,    RegDeadzone,     17'd32768,  8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegDeadzoneGain, 17'd8192,   8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_REG,    RegSmoothFactor, 17'd65536,  8'd0,   8'd0,   13'd0,    1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd191, 8'd63,  13'd3000, 1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd150, 8'd100, 13'd42,   1'b0, 0, 0},
    '{ROW_SAMPLE, RegDeadzone,     17'd0,      8'd85,  8'd170, 13'd5000, 1'b0, 0, 0}
  };

  joystick_deadzone_smoother_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Right shift by sh with the half rounded up; all operands here are magnitudes.
  function automatic longint unsigned round_half_up(longint unsigned v, int unsigned sh);
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // Shaped value of one centered axis (-128..128): scale to Q2.14, cut the
  // deadzone, rescale by the gain, apply speed, clamp to one, restore the sign.
  function automatic logic signed [AxisW-1:0] axis_target(int a);
    longint unsigned mag, q14, q16, r;
    mag = (a < 0) ? -a : a;
    q14 = (mag * 16384 + 63) / 127;
    q16 = q14 << 2;
    if (q16 < dz_thresh) return '0;
    r = round_half_up((q16 - dz_thresh) * dz_rescale, 14);
    r = round_half_up(r * speed_mul, 12);
    if (r > 16384) r = 16384;
    return AxisW'((a < 0) ? -int'(r) : int'(r));
  endfunction

  // Moves the held value toward the target by the smoothing weight, which
  // saturates at one.
  function automatic logic signed [AxisW-1:0] blend_toward(logic signed [AxisW-1:0] held,
                                                           logic signed [AxisW-1:0] target);
    longint unsigned w, mag;
    int              diff, q;
    w    = (blend_weight > 17'd65536) ? 65536 : blend_weight;
    diff = int'(target) - int'(held);
    mag  = (diff < 0) ? -diff : diff;
    q    = int'(round_half_up(mag * w, 16));
    return AxisW'((diff < 0) ? int'(held) - q : int'(held) + q);
  endfunction

  // Advances our copy of the state by one accepted item and returns its result.
  function automatic out_item_t predict_sample(in_item_t it);
    out_item_t res;
    lat_held = blend_toward(lat_held, axis_target(int'(it.pad_x) - 127));
    fwd_held = blend_toward(fwd_held, axis_target(127 - int'(it.pad_y)));
    samples_seen++;
    res.smooth_x     = lat_held;
    res.smooth_y     = fwd_held;
    res.yaw_out      = it.yaw_angle;
    res.sample_count = samples_seen;
    res.is_active    = 1'b1;
    return res;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Pad bytes lean toward the full-scale ends and the center, where the
  // saturation and the deadzone edge live.
  function automatic logic [PadW-1:0] pick_pad();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1:       return PadW'($urandom_range(118, 136));
      default: return PadW'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge. Offers one item, optionally after a random gap, and
  // returns at the falling edge after it was taken with valid still high, so the
  // next call can keep valid up without a glitch.
  task automatic send_sample(in_item_t it, logic fixed,
                             logic signed [AxisW-1:0] want_x, logic signed [AxisW-1:0] want_y);
    out_item_t want;
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    want = predict_sample(it);
    // Rows with a result known by inspection are checked against the typed value.
    if (fixed) begin
      want.smooth_x = want_x;
      want.smooth_y = want_y;
    end
    pending_results.push_back(want);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering items and waits until the block has returned every result
  // and its sequencer has had time to come to rest.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  // One register write, pulsed for a single cycle; only called while settled.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      RegDeadzone:     dz_thresh    = val[15:0];
      RegDeadzoneGain: dz_rescale   = val[15:0];
      RegSpeedFactor:  speed_mul    = val[15:0];
      RegSmoothFactor: blend_weight = val;
      default:         ;
    endcase
    settings_used++;
  endtask

  // Result side: ready drops at random while gaps are on, except for the one long hold
  // that lets the output register fill and forces the block to stall its input.
  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= (gaps_on && $urandom_range(0, 99) < 11) ? 1'b0 : 1'b1;
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: count %0d", out_data_o.sample_count);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("smooth_x", longint'(want.smooth_x), longint'(out_data_o.smooth_x));
        check_field("smooth_y", longint'(want.smooth_y), longint'(out_data_o.smooth_y));
        check_field("yaw_out", longint'(want.yaw_out), longint'(out_data_o.yaw_out));
        check_field("sample_count", longint'(want.sample_count),
                    longint'(out_data_o.sample_count));
        check_field("is_active", longint'(want.is_active), longint'(out_data_o.is_active));
        results_checked++;
      end
    end
  end

  // A run is hung when neither channel moves an item for a long time; the long
  // hold and the pauses before register writes stay far below the limit.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_joystick_deadzone_smoother_unit NOT OK");
    $finish;
  end

  initial begin : stimulus
    in_item_t        it;
    bit              prev_reg;
    int unsigned     dir_samples;
    longint unsigned dz, gain;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegDeadzone;
    cfg_data_i      = '0;
    fails           = 0;
    results_checked = 0;
    samples_sent    = 0;
    settings_used   = 0;
    gaps_on         = 1'b1;
    hold_req        = 1'b0;
    prev_reg        = 1'b0;
    // Register and state values the block takes on reset.
    dz_thresh    = 16'd0;
    dz_rescale   = 16'd4096;
    speed_mul    = 16'd4096;
    blend_weight = 17'd65536;
    lat_held     = '0;
    fwd_held     = '0;
    samples_seen = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. A run of register rows is preceded by a full drain.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!prev_reg) settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        prev_reg = 1'b1;
      end else begin
        it.pad_x     = dir_rows[i].pad_x;
        it.pad_y     = dir_rows[i].pad_y;
        it.yaw_angle = dir_rows[i].yaw;
        send_sample(it, dir_rows[i].fixed, dir_rows[i].want_x, dir_rows[i].want_y);
        prev_reg = 1'b0;
      end
    end
    dir_samples = samples_sent;

    // Random phases, each under a fresh setting of all four registers. The gain
    // mostly follows the deadzone as software would set it, sometimes not.
    // One phase runs without any idling, another starts with the long hold.
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       dz = 0;
        1:       dz = 65535;
        default: dz = $urandom_range(0, 24000);
      endcase
      case ($urandom_range(0, 5))
        4:       gain = $urandom_range(0, 4095);
        5:       gain = $urandom_range(4096, 65535);
        default: begin
          gain = (64'd1 << 28) / (65536 - dz);
          if (gain > 65535) gain = 65535;
        end
      endcase
      write_reg(RegDeadzone, CfgW'(dz));
      write_reg(RegDeadzoneGain, CfgW'(gain));
      case ($urandom_range(0, 5))
        0:       write_reg(RegSpeedFactor, 17'd0);
        1:       write_reg(RegSpeedFactor, 17'd65535);
        default: write_reg(RegSpeedFactor, CfgW'($urandom_range(2048, 12288)));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(RegSmoothFactor, 17'd0);
        1:       write_reg(RegSmoothFactor, 17'd65536);
        2:       write_reg(RegSmoothFactor, CfgW'($urandom_range(65537, 131071)));
        default: write_reg(RegSmoothFactor, CfgW'($urandom_range(1, 65536)));
      endcase
      gaps_on = (p != 2);
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.pad_x     = pick_pad();
        it.pad_y     = pick_pad();
        it.yaw_angle = ($urandom_range(0, 7) == 0) ? YawW'($urandom_range(5760, 8191))
                                                   : YawW'($urandom_range(0, 5759));
        send_sample(it, 1'b0, '0, '0);
      end
    end
    gaps_on = 1'b1;

    settle();
    $display("Sent %0d items (%0d from the directed table) under %0d register writes;",
             samples_sent, dir_samples, settings_used);
    $display("checked %0d results, with one %0d-cycle output hold and a phase without gaps.",
             results_checked, HOLD_CYCLES);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("tb_joystick_deadzone_smoother_unit OK");
    end else begin
      $display("tb_joystick_deadzone_smoother_unit NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/jds_pkg.sv
rtl/core/jds_mul_unit.sv
rtl/core/joystick_deadzone_smoother_unit.sv
tb/tb_joystick_deadzone_smoother_unit.sv
